FILE: rtl/dbpd_pkg.sv
// Shared types, constants and helper functions for the dual brushed phase drive mapper.
package dbpd_pkg;

    localparam int DUTY_W     = 16;
    localparam int MODE_W     = 2;
    localparam int PMAP_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUO_W      = 16;               // quotient bits, one per divider stage
    localparam int PROD_W     = 2 * DUTY_W;       // d * mid
    localparam int TOT_W      = DUTY_W + 1;       // d1 + d2
    localparam int IN_W       = 3 * DUTY_W;
    localparam int RES_W      = 3 * (DUTY_W + MODE_W);
    localparam int OUT_W      = ((RES_W + 7) / 8) * 8;

    localparam int PHASE_OFFSET = 0;              // 0 to 2
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_ENABLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_MAP      = 3'd4;

    localparam logic [DUTY_W-1:0] PWM_PERIOD_RST = 16'd2048;
    localparam logic [DUTY_W-1:0] DEAD_TIME_RST  = 16'd32;

    typedef enum logic [MODE_W-1:0] {
        MODE_COMP = 2'd0,
        MODE_OD   = 2'd1,
        MODE_HI   = 2'd2,
        MODE_FLT  = 2'd3
    } t_mode;

    // which motor phase lands on hardware phase A
    typedef enum logic [1:0] {
        PMAP_SHARED_A = 2'd0,
        PMAP_LEFT_A   = 2'd1,
        PMAP_RIGHT_A  = 2'd2
    } t_pmap;

    typedef struct packed {
        logic [DUTY_W-1:0] right_duty;
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] common_duty;
    } t_duty_in;

    // what travels alongside the divider
    typedef struct packed {
        logic [DUTY_W-1:0] cm;
        logic [DUTY_W-1:0] lf;
        logic [DUTY_W-1:0] rt;
        logic              act;
        logic              up;
        logic              scale;
        logic [DUTY_W-1:0] d1;
        logic [DUTY_W-1:0] d2;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [DUTY_W-1:0] mid;
        logic [TOT_W-1:0]  tot;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        t_mode             mode_c;
        logic [DUTY_W-1:0] duty_c;
        t_mode             mode_b;
        logic [DUTY_W-1:0] duty_b;
        t_mode             mode_a;
        logic [DUTY_W-1:0] duty_a;
    } t_result;

    // 9-bit value mod 3 via base-4 digit sums (4 == 1 mod 3)
    function automatic logic [1:0] mod3_9(input logic [8:0] v);
        logic [3:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = 4'(v[8]) + 4'(v[7:6]) + 4'(v[5:4]) + 4'(v[3:2]) + 4'(v[1:0]);
        s2 = 3'(s1[3:2]) + 3'(s1[1:0]);
        s3 = 3'(s2[2]) + 3'(s2[1:0]);
        return (s3 == 3'd3) ? 2'd0 : s3[1:0];
    endfunction

    function automatic t_pmap pmap_from_raw(input logic [PMAP_W-1:0] raw);
        logic [PMAP_W-1:0] adj;
        logic [8:0]        sum;
        adj = (raw != '0) ? raw - 1'b1 : '0;
        sum = 9'(adj) + 9'(PHASE_OFFSET);
        return t_pmap'(mod3_9(sum));
    endfunction

    function automatic t_mode side_mode(input logic [DUTY_W-1:0] own,
                                        input logic [DUTY_W-1:0] shared);
        t_mode m;
        if (own > shared) begin
            m = MODE_HI;
        end else if (own < shared) begin
            m = MODE_OD;
        end else begin
            m = MODE_FLT;
        end
        return m;
    endfunction

endpackage

FILE: rtl/dbpd_front.sv
// Front end: takes input items, classifies direction and computes the balance terms.
module dbpd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  dbpd_pkg::t_duty_in      i_duty,
    input  logic [dbpd_pkg::DUTY_W-1:0] i_pwm_period,
    input  logic [dbpd_pkg::DUTY_W-1:0] i_dead_time,
    input  logic                    i_balance,
    input  dbpd_pkg::t_q_stat       i_q_stat,
    output logic                    o_push,
    output dbpd_pkg::t_work         o_work
);

    logic               r_valid;
    dbpd_pkg::t_duty_in r_duty;

    logic [dbpd_pkg::DUTY_W-1:0] cm, lf, rt, maxd, mid, d1, d2;
    logic [dbpd_pkg::TOT_W-1:0]  mid_sum, tot;
    logic                        up, down, act;

    assign o_ready = !r_valid || !i_q_stat.full;
    assign o_push  = r_valid && !i_q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_duty <= i_duty;
        end
    end

    always_comb begin
        cm      = r_duty.common_duty;
        lf      = r_duty.left_duty;
        rt      = r_duty.right_duty;
        maxd    = i_pwm_period - i_dead_time;
        mid_sum = {1'b0, maxd} + 1'b1;
        mid     = mid_sum[dbpd_pkg::TOT_W-1:1];
        up      = (lf >= cm) && (rt >= cm);
        down    = !up && (lf <= cm) && (rt <= cm);
        d1      = up ? lf - cm : cm - lf;
        d2      = up ? rt - cm : cm - rt;
        tot     = {1'b0, d1} + {1'b0, d2};
        act     = i_balance && (up || down);

        o_work.side.cm    = cm;
        o_work.side.lf    = lf;
        o_work.side.rt    = rt;
        o_work.side.act   = act;
        o_work.side.up    = up;
        o_work.side.scale = act && (tot > {1'b0, mid});
        o_work.side.d1    = d1;
        o_work.side.d2    = d2;
        o_work.mid        = mid;
        o_work.tot        = tot;
    end

endmodule

FILE: rtl/dbpd_fifo.sv
// Short queue of classified items between front and back.
module dbpd_fifo #(
    parameter int DEPTH = dbpd_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dbpd_pkg::t_work   i_wdata,
    input  logic              i_pop,
    output dbpd_pkg::t_work   o_rdata,
    output dbpd_pkg::t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dbpd_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rdata      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/dbpd_div.sv
// Pipelined restoring divider lane, one quotient bit per stage.
module dbpd_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [dbpd_pkg::PROD_W-1:0]  i_num,
    input  logic [dbpd_pkg::TOT_W-1:0]   i_den,
    output logic [dbpd_pkg::QUO_W-1:0]   o_quo
);

    localparam int QW = dbpd_pkg::QUO_W;
    localparam int TW = dbpd_pkg::TOT_W;

    // quotient fits in QW bits, so the upper half of num starts below den
    logic [TW-1:0] r_rem [QW-1];
    logic [QW-1:0] r_low [QW-1];
    logic [TW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [TW-1:0] rem_in, den_in;
        logic [QW-1:0] low_in, quo_in;
        logic [TW:0]   trial, diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = TW'(i_num[dbpd_pkg::PROD_W-1:QW]);
            assign low_in = i_num[QW-1:0];
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {quo_in[QW-2:0], ge};
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? diff[TW-1:0] : trial[TW-1:0];
                    r_low[k] <= {low_in[QW-2:0], 1'b0};
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

FILE: rtl/dbpd_back.sv
// Back end: scales balanced differences, applies braking, modes and phase map.
module dbpd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_pop,
    input  dbpd_pkg::t_work       i_work,
    input  logic                  i_brake,
    input  dbpd_pkg::t_pmap       i_pmap,
    output logic                  o_valid,
    input  logic                  i_ready,
    output dbpd_pkg::t_result     o_res
);

    localparam int QW = dbpd_pkg::QUO_W;
    localparam int DW = dbpd_pkg::DUTY_W;

    logic                         en;
    logic                         r_p_valid;
    dbpd_pkg::t_side              r_p_side;
    logic [dbpd_pkg::PROD_W-1:0]  r_p1, r_p2;
    logic [dbpd_pkg::TOT_W-1:0]   r_p_den;
    logic [QW-1:0]                r_s_valid;
    dbpd_pkg::t_side              r_s_side [QW];
    logic                         r_out_valid;
    dbpd_pkg::t_result            r_res, n_res;
    logic [QW-1:0]                q1, q2;

    // whole back pipeline moves together when the output slot frees up
    assign en      = !r_out_valid || i_ready;
    assign o_pop   = en && i_q_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_s_valid   <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_p_valid   <= i_q_valid;
            r_s_valid   <= {r_s_valid[QW-2:0], r_p_valid};
            r_out_valid <= r_s_valid[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_side <= i_work.side;
            r_p1     <= dbpd_pkg::PROD_W'(i_work.side.d1) * dbpd_pkg::PROD_W'(i_work.mid);
            r_p2     <= dbpd_pkg::PROD_W'(i_work.side.d2) * dbpd_pkg::PROD_W'(i_work.mid);
            r_p_den  <= i_work.tot;
            r_s_side[0] <= r_p_side;
            for (int k = 1; k < QW; k++) begin
                r_s_side[k] <= r_s_side[k-1];
            end
            r_res <= n_res;
        end
    end

    dbpd_div u_div_left (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_p1),
        .i_den (r_p_den),
        .o_quo (q1)
    );

    dbpd_div u_div_right (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_p2),
        .i_den (r_p_den),
        .o_quo (q2)
    );

    always_comb begin
        dbpd_pkg::t_side side;
        logic [DW-1:0]   d1f, d2f, cm, lf, rt;
        dbpd_pkg::t_mode ms, ml, mr;

        side = r_s_side[QW-1];
        d1f  = side.scale ? q1 : side.d1;
        d2f  = side.scale ? q2 : side.d2;
        cm   = side.cm;
        if (side.act) begin
            lf = side.up ? cm + d1f : cm - d1f;
            rt = side.up ? cm + d2f : cm - d2f;
        end else begin
            lf = side.lf;
            rt = side.rt;
        end

        if (i_brake && cm == lf && cm == rt) begin
            cm = '0;
            lf = '0;
            rt = '0;
        end

        if (i_brake) begin
            ms = dbpd_pkg::MODE_COMP;
            ml = dbpd_pkg::MODE_COMP;
            mr = dbpd_pkg::MODE_COMP;
        end else begin
            ms = (cm == '0 && lf == '0 && rt == '0) ? dbpd_pkg::MODE_FLT
                                                     : dbpd_pkg::MODE_COMP;
            ml = dbpd_pkg::side_mode(lf, cm);
            mr = dbpd_pkg::side_mode(rt, cm);
        end

        unique case (i_pmap)
            dbpd_pkg::PMAP_LEFT_A: begin
                n_res.duty_a = lf; n_res.mode_a = ml;
                n_res.duty_b = cm; n_res.mode_b = ms;
                n_res.duty_c = rt; n_res.mode_c = mr;
            end
            dbpd_pkg::PMAP_RIGHT_A: begin
                n_res.duty_a = rt; n_res.mode_a = mr;
                n_res.duty_b = cm; n_res.mode_b = ms;
                n_res.duty_c = lf; n_res.mode_c = ml;
            end
            default: begin
                n_res.duty_a = cm; n_res.mode_a = ms;
                n_res.duty_b = lf; n_res.mode_b = ml;
                n_res.duty_c = rt; n_res.mode_c = mr;
            end
        endcase
    end

endmodule

FILE: rtl/dual_brushed_phase_drive_mapper_top.sv
// Top level of the dual brushed phase drive mapper: config registers, front, queue, back.
//
//  channel   dir  handshake                         payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready   common, left, right duty
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready   duty/mode for phases A, B, C
//  cfg       in   i_cfg_valid/o_cfg_ready           register index, write data
//
// One item per cycle sustained while m_axis is ready. From accept to o_m_axis_tvalid:
// queue write, product register, the 16-stage divider quotient pipeline, output register.
// Reset is synchronous: valids and queue pointers clear, config returns to defaults.
// A stall on m_axis freezes the back pipeline; the queue and front register then fill
// and o_s_axis_tready drops. o_cfg_ready is always high.
module dual_brushed_phase_drive_mapper_top #(
    parameter int QUEUE_DEPTH = dbpd_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [15:0] common_duty, [31:16] left_duty, [47:32] right_duty
    input  logic [dbpd_pkg::IN_W-1:0]          i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [15:0] duty_a, [17:16] mode_a, [33:18] duty_b, [35:34] mode_b,
    // [51:36] duty_c, [53:52] mode_c, [55:54] zero
    output logic [dbpd_pkg::OUT_W-1:0]         o_m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dbpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dbpd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int INFLIGHT_CAP = QUEUE_DEPTH + dbpd_pkg::QUO_W + 3;
    localparam int IFW          = $clog2(INFLIGHT_CAP + 1);

    logic [dbpd_pkg::DUTY_W-1:0] r_pwm_period, r_dead_time;
    logic                        r_brake, r_balance;
    dbpd_pkg::t_pmap             r_pmap;

    logic              q_push, q_pop;
    dbpd_pkg::t_work   q_wdata, q_rdata;
    dbpd_pkg::t_q_stat q_stat;
    dbpd_pkg::t_result res;
    logic [IFW-1:0]    r_inflight;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= dbpd_pkg::PWM_PERIOD_RST;
            r_dead_time  <= dbpd_pkg::DEAD_TIME_RST;
            r_brake      <= 1'b0;
            r_balance    <= 1'b0;
            r_pmap       <= dbpd_pkg::pmap_from_raw('0);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dbpd_pkg::CFG_PWM_PERIOD:     r_pwm_period <= i_cfg_data;
                dbpd_pkg::CFG_DEAD_TIME:      r_dead_time  <= i_cfg_data;
                dbpd_pkg::CFG_BRAKE_ENABLE:   r_brake      <= i_cfg_data[0];
                dbpd_pkg::CFG_BALANCE_ENABLE: r_balance    <= i_cfg_data[0];
                dbpd_pkg::CFG_PHASE_MAP:
                    r_pmap <= dbpd_pkg::pmap_from_raw(i_cfg_data[dbpd_pkg::PMAP_W-1:0]);
                default: ;
            endcase
        end
    end

    dbpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_duty       (dbpd_pkg::t_duty_in'(i_s_axis_tdata)),
        .i_pwm_period (r_pwm_period),
        .i_dead_time  (r_dead_time),
        .i_balance    (r_balance),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_work       (q_wdata)
    );

    dbpd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_stat  (q_stat)
    );

    dbpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!q_stat.empty),
        .o_pop     (q_pop),
        .i_work    (q_rdata),
        .i_brake   (r_brake),
        .i_pmap    (r_pmap),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (res)
    );

    assign o_m_axis_tdata = {(dbpd_pkg::OUT_W - dbpd_pkg::RES_W)'(0), res};

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            unique case ({i_s_axis_tvalid && o_s_axis_tready,
                          o_m_axis_tvalid && i_m_axis_tready})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_q_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_inflight <= IFW'(INFLIGHT_CAP)))
        else $error("more items in flight than pipeline capacity");

    a_out_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_inflight != '0))
        else $error("result shown with no item in flight");

endmodule

FILE: tb/testbench.sv
// Testbench for the dual brushed phase drive mapper: a table of duty items, then random phases.
module testbench;
    import dbpd_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 4;
    localparam int MAX_WAIT     = 12;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 52;
    localparam int HOLD_PHASE   = 4;
    localparam int DRAIN_PHASE  = 6;
    localparam int HOLD_CYCLES  = 200;
    localparam int PLAN_ROWS    = 25;
    localparam int CFG_SLOTS    = 1 << CFG_IDX_W;
    localparam int CFG_FIRST_UNUSED = int'(CFG_PHASE_MAP) + 1;

    localparam logic [DUTY_W-1:0] DUTY_MAX = '1;
    localparam logic [DUTY_W-1:0] CORNER [6] = '{16'h0000, 16'h0001, 16'h7FFF,
                                                 16'h8000, 16'hFFFE, 16'hFFFF};

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_LIGHT,
        PACE_RANDOM
    } t_pace;

    typedef struct {
        logic [DUTY_W-1:0] period;
        logic [DUTY_W-1:0] dead;
        logic              brake;
        logic              balance;
        logic [PMAP_W-1:0] pmap;
        logic [DUTY_W-1:0] cm;
        logic [DUTY_W-1:0] lf;
        logic [DUTY_W-1:0] rt;
        bit                typed;
        t_result           res;
    } t_drive_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    t_duty_in              s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // register copy as the block should hold it
    logic [DUTY_W-1:0] cfg_period  = PWM_PERIOD_RST;
    logic [DUTY_W-1:0] cfg_dead    = DEAD_TIME_RST;
    logic              cfg_brake   = 1'b0;
    logic              cfg_balance = 1'b0;
    logic [PMAP_W-1:0] cfg_map     = '0;

    t_result    pending_drives [$];
    t_drive_row drive_plan [PLAN_ROWS];
    t_pace      tx_pace = PACE_RANDOM;
    t_pace      rx_pace = PACE_RANDOM;
    bit         hold_request = 1'b0;
    int         mismatches = 0;
    int         items_sent = 0;
    int         results_checked = 0;
    int         settings_applied = 0;
    int         scaled_items = 0;
    int         brake_stops = 0;

    dual_brushed_phase_drive_mapper_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("%0t: timeout, %0d results still outstanding", $time, pending_drives.size());
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_mode motor_pin(input logic [DUTY_W-1:0] own,
                                        input logic [DUTY_W-1:0] shared);
        return (own > shared) ? MODE_HI : ((own < shared) ? MODE_OD : MODE_FLT);
    endfunction

    function automatic t_result phase_set(input logic [DUTY_W-1:0] da, input t_mode ma,
                                          input logic [DUTY_W-1:0] db, input t_mode mb,
                                          input logic [DUTY_W-1:0] dc, input t_mode mc);
        return '{mode_c: mc, duty_c: dc, mode_b: mb, duty_b: db, mode_a: ma, duty_a: da};
    endfunction

    // balance, brake, pin modes, then phase rotation, all from the register copy
    function automatic t_result map_phase_drives(input t_duty_in item);
        logic [DUTY_W-1:0] cm, lf, rt, span, d1, d2;
        logic [DUTY_W:0]   half, total;
        logic              up, down;
        t_mode             m_sh, m_lf, m_rt;
        int                route;
        cm = item.common_duty;
        lf = item.left_duty;
        rt = item.right_duty;
        if (cfg_balance) begin
            span = cfg_period - cfg_dead;
            half = ({1'b0, span} + 1'b1) >> 1;
            up   = (lf >= cm) && (rt >= cm);
            down = !up && (lf <= cm) && (rt <= cm);
            if (up || down) begin
                d1 = up ? lf - cm : cm - lf;
                d2 = up ? rt - cm : cm - rt;
                total = {1'b0, d1} + {1'b0, d2};
                if (total > half) begin
                    d1 = DUTY_W'((64'(d1) * 64'(half)) / 64'(total));
                    d2 = DUTY_W'((64'(d2) * 64'(half)) / 64'(total));
                    scaled_items++;
                end
                lf = up ? cm + d1 : cm - d1;
                rt = up ? cm + d2 : cm - d2;
            end
        end
        if (cfg_brake && cm == lf && cm == rt) begin
            cm = '0;
            lf = '0;
            rt = '0;
            brake_stops++;
        end
        if (cfg_brake) begin
            m_sh = MODE_COMP;
            m_lf = MODE_COMP;
            m_rt = MODE_COMP;
        end else begin
            m_sh = (cm == '0 && lf == '0 && rt == '0) ? MODE_FLT : MODE_COMP;
            m_lf = motor_pin(lf, cm);
            m_rt = motor_pin(rt, cm);
        end
        // no 8-bit wrap: map 0 and 1 both land on rotation 0
        route = ((cfg_map != '0) ? int'(cfg_map) - 1 : 0) + PHASE_OFFSET;
        case (t_pmap'(2'(route % 3)))
            PMAP_LEFT_A:  return phase_set(lf, m_lf, cm, m_sh, rt, m_rt);
            PMAP_RIGHT_A: return phase_set(rt, m_rt, cm, m_sh, lf, m_lf);
            default:      return phase_set(cm, m_sh, lf, m_lf, rt, m_rt);
        endcase
    endfunction

    function automatic int pick_wait(input t_pace p);
        case (p)
            PACE_FULL:  return 0;
            PACE_LIGHT: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
            default:    return $urandom_range(0, MAX_WAIT);
        endcase
    endfunction

    function automatic logic [DUTY_W-1:0] pick_ticks(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return DUTY_MAX;
            2:       return DUTY_W'($urandom);
            default: return DUTY_W'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PWM_PERIOD:     cfg_period  = val;
            CFG_DEAD_TIME:      cfg_dead    = val;
            CFG_BRAKE_ENABLE:   cfg_brake   = val[0];
            CFG_BALANCE_ENABLE: cfg_balance = val[0];
            CFG_PHASE_MAP:      cfg_map     = val[PMAP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        wait (pending_drives.size() == 0);
        @(posedge clk);
    endtask

    // unused upper bits of the flag and map writes are filled with noise
    task automatic program_drive(input logic [DUTY_W-1:0] period, input logic [DUTY_W-1:0] dead,
                                 input logic brake, input logic balance,
                                 input logic [PMAP_W-1:0] pmap);
        wait_drained();
        write_reg(CFG_PWM_PERIOD, period);
        write_reg(CFG_DEAD_TIME, dead);
        write_reg(CFG_BRAKE_ENABLE, {15'($urandom), brake});
        write_reg(CFG_BALANCE_ENABLE, {15'($urandom), balance});
        write_reg(CFG_PHASE_MAP, {8'($urandom), pmap});
        settings_applied++;
    endtask

    // returns at the edge that took the item, with valid still high
    task automatic offer_duties(input t_duty_in item, input bit typed, input t_result typed_res);
        int gap;
        gap = pick_wait(tx_pace);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_drives.push_back(typed ? typed_res : map_phase_drives(item));
        items_sent++;
    endtask

    task automatic check_field(input string name, input logic [DUTY_W-1:0] want,
                               input logic [DUTY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_result got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[RES_W-1:0]);
            if (pending_drives.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                mismatches++;
            end else begin
                want = pending_drives.pop_front();
                check_field("duty_a", want.duty_a, got.duty_a);
                check_field("mode_a", DUTY_W'(want.mode_a), DUTY_W'(got.mode_a));
                check_field("duty_b", want.duty_b, got.duty_b);
                check_field("mode_b", DUTY_W'(want.mode_b), DUTY_W'(got.mode_b));
                check_field("duty_c", want.duty_c, got.duty_c);
                check_field("mode_c", DUTY_W'(want.mode_c), DUTY_W'(got.mode_c));
                results_checked++;
            end
        end
    end

    initial begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = pick_wait(rx_pace);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial begin : stimulus
        t_drive_row        r;
        t_duty_in          item;
        logic [DUTY_W-1:0] period, dead;
        logic [PMAP_W-1:0] pmap;
        int unsigned       base, mag_l, mag_r;

        drive_plan = '{
            // reset settings: extremes and the float cases
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b0, 8'd0, 16'd0, 16'd0, 16'd0,
              1'b1, phase_set(16'd0, MODE_FLT, 16'd0, MODE_FLT, 16'd0, MODE_FLT)},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b0, 8'd0, DUTY_MAX, DUTY_MAX, DUTY_MAX,
              1'b1, phase_set(DUTY_MAX, MODE_COMP, DUTY_MAX, MODE_FLT, DUTY_MAX, MODE_FLT)},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b0, 8'd0, 16'd0, DUTY_MAX, 16'd0,
              1'b1, phase_set(16'd0, MODE_COMP, DUTY_MAX, MODE_HI, 16'd0, MODE_FLT)},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b0, 8'd0, DUTY_MAX, 16'd0, DUTY_MAX,
              1'b1, phase_set(DUTY_MAX, MODE_COMP, 16'd0, MODE_OD, DUTY_MAX, MODE_FLT)},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b0, 8'd0, 16'd0, 16'd0, 16'd1,
              1'b1, phase_set(16'd0, MODE_COMP, 16'd0, MODE_FLT, 16'd1, MODE_HI)},
            // every rotation, including the top map value
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b0, 8'd1, 16'd1000, 16'd2000, 16'd500,
              1'b0, '0},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b0, 8'd2, 16'd1000, 16'd2000, 16'd500,
              1'b0, '0},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b0, 8'd3, 16'd1000, 16'd2000, 16'd500,
              1'b0, '0},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b0, 8'd255, 16'd1000, 16'd2000, 16'd500,
              1'b0, '0},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b0, 8'd4, 16'd1000, 16'd2000, 16'd500,
              1'b0, '0},
            // braking: equal duties stop, everything complementary
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b1, 1'b0, 8'd0, 16'd500, 16'd500, 16'd500,
              1'b1, phase_set(16'd0, MODE_COMP, 16'd0, MODE_COMP, 16'd0, MODE_COMP)},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b1, 1'b0, 8'd0, 16'd0, 16'd0, 16'd0,
              1'b1, phase_set(16'd0, MODE_COMP, 16'd0, MODE_COMP, 16'd0, MODE_COMP)},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b1, 1'b0, 8'd0, 16'd100, 16'd200, 16'd300,
              1'b0, '0},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b1, 1'b0, 8'd2, DUTY_MAX, 16'd0, 16'd1234,
              1'b0, '0},
            // balancing: up, down, mixed, sum at and just over the limit
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b1, 8'd0, 16'd1000, 16'd2000, 16'd1500,
              1'b0, '0},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b1, 8'd0, 16'd3000, 16'd1000, 16'd2000,
              1'b0, '0},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b1, 8'd0, 16'd1000, 16'd2000, 16'd500,
              1'b0, '0},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b1, 8'd0, 16'd0, 16'd1008, 16'd0,
              1'b0, '0},
            '{PWM_PERIOD_RST, DEAD_TIME_RST, 1'b0, 1'b1, 8'd0, 16'd0, 16'd1009, 16'd0,
              1'b0, '0},
            '{DUTY_MAX, 16'd0, 1'b0, 1'b1, 8'd0, DUTY_MAX, 16'd0, DUTY_MAX, 1'b0, '0},
            '{DUTY_MAX, 16'd0, 1'b0, 1'b1, 8'd0, 16'd0, DUTY_MAX, DUTY_MAX, 1'b0, '0},
            // dead time above period wraps the maximum duty
            '{16'd10, 16'd20, 1'b0, 1'b1, 8'd0, 16'd0, DUTY_MAX, 16'd1, 1'b0, '0},
            // zero limit collapses to equal duties, which the brake then stops
            '{16'd0, 16'd0, 1'b1, 1'b1, 8'd0, 16'd500, 16'd900, 16'd700, 1'b0, '0},
            '{16'd0, 16'd0, 1'b0, 1'b1, 8'd2, 16'd1234, DUTY_MAX, 16'd2000, 1'b0, '0},
            '{16'd0, DUTY_MAX, 1'b0, 1'b1, 8'd3, 16'd100, 16'd101, 16'd102, 1'b0, '0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // writes to unused slots must leave every register alone
        for (int k = CFG_FIRST_UNUSED; k < CFG_SLOTS; k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        end

        foreach (drive_plan[i]) begin
            r = drive_plan[i];
            if (r.period != cfg_period || r.dead != cfg_dead || r.brake != cfg_brake ||
                r.balance != cfg_balance || r.pmap != cfg_map) begin
                program_drive(r.period, r.dead, r.brake, r.balance, r.pmap);
            end
            item = '{right_duty: r.rt, left_duty: r.lf, common_duty: r.cm};
            offer_duties(item, r.typed, r.res);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            period = pick_ticks(256, 8192);
            dead   = pick_ticks(0, 200);
            pmap   = ($urandom_range(0, 3) == 0) ? PMAP_W'($urandom_range(0, 3))
                                                 : PMAP_W'($urandom);
            if (ph == 0) begin
                period = DUTY_MAX;
                dead   = '0;
            end
            if (ph == 1) begin
                period = '0;
                dead   = DUTY_MAX;
            end
            if (ph == 2) pmap = '0;
            if (ph == 3) pmap = '1;
            program_drive(period, dead, $urandom_range(0, 2) == 0, $urandom_range(0, 3) != 0,
                          pmap);
            tx_pace = t_pace'($urandom_range(0, 2));
            rx_pace = t_pace'($urandom_range(0, 2));
            if (ph == HOLD_PHASE) begin
                // long output stall while input keeps coming: fills the queue
                tx_pace = PACE_FULL;
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == DRAIN_PHASE && n == PHASE_ITEMS / 2) wait_drained();
                base = $urandom_range(0, DUTY_MAX);
                case ($urandom_range(0, 9))
                    0, 1, 2: item = t_duty_in'(IN_W'({$urandom, $urandom}));
                    3: item = '{right_duty: DUTY_W'(base), left_duty: DUTY_W'(base),
                                common_duty: DUTY_W'(base)};
                    4: begin
                        item.common_duty = DUTY_W'(base);
                        item.left_duty   = DUTY_W'(base + $urandom_range(0, 2) - 1);
                        item.right_duty  = DUTY_W'(base + $urandom_range(0, 2) - 1);
                    end
                    5: begin
                        item.common_duty = CORNER[$urandom_range(0, 5)];
                        item.left_duty   = CORNER[$urandom_range(0, 5)];
                        item.right_duty  = CORNER[$urandom_range(0, 5)];
                    end
                    default: begin
                        // same direction on both motors, spread over all magnitudes
                        mag_l = $urandom & ((32'd1 << $urandom_range(1, DUTY_W)) - 1);
                        mag_r = $urandom & ((32'd1 << $urandom_range(1, DUTY_W)) - 1);
                        item.common_duty = DUTY_W'(base);
                        if ($urandom_range(0, 1) == 1) begin
                            item.left_duty  = (base + mag_l > DUTY_MAX) ? DUTY_MAX
                                                                        : DUTY_W'(base + mag_l);
                            item.right_duty = (base + mag_r > DUTY_MAX) ? DUTY_MAX
                                                                        : DUTY_W'(base + mag_r);
                        end else begin
                            item.left_duty  = (mag_l > base) ? '0 : DUTY_W'(base - mag_l);
                            item.right_duty = (mag_r > base) ? '0 : DUTY_W'(base - mag_r);
                        end
                    end
                endcase
                offer_duties(item, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run: %0d items (%0d from the table), %0d results checked, %0d settings.",
                 items_sent, PLAN_ROWS, results_checked, settings_applied);
        $display("Balance scaling on %0d items, brake stop on %0d, one %0d-cycle output hold.",
                 scaled_items, brake_stops, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
